@@ rtl/gmd_pkg.sv @@
// shared types and constants for the grid maze depth-first solver
// no dependencies; used by the top level and the testbench

package gmd_pkg;

   // default sizes
   localparam int MAX_DIM_DEF   = 64;
   localparam int MAX_CELLS_DEF = 4096;

   // fixed port field widths
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 12;
   localparam int CFG_W    = 7;
   localparam int START_W  = 6;
   localparam int STATUS_W = 2;
   localparam int PATH_W   = 6;
   localparam int CSR_IDX_W = 2;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SOLVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_PATH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_READ = 2'd2;
   localparam logic [STATUS_W-1:0] ST_LOADED  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_START_COL   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_START_ROW   = 2'd3;

   // neighbor visiting order
   typedef enum logic [1:0] {
      NBR_LEFT,
      NBR_RIGHT,
      NBR_UP,
      NBR_DOWN
   } nbr_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_CLR_RD,
      S_CLR_WR,
      S_ST_CHECK,
      S_ST_WAIT,
      S_POP,
      S_POP_WAIT,
      S_NB_SEL,
      S_NB_WAIT,
      S_RD_WAIT,
      S_RESPOND
   } state_type;

endpackage

@@ rtl/gmd_ram.sv @@
// generic single-port synchronous ram with registered read
// no dependencies; used for the cell store and the search stack

module gmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/grid_maze_dfs_solver_top.sv @@
// top level of the grid maze depth-first solver: sequencer, registers, ports
// depends on gmd_pkg and gmd_ram (cell store and search stack)

// Load requests write one grid cell and answer from the respond state.
// Read requests walk the parent links from the goal toward the start, one
// cell each; every cell but the start also passes the read-wait state.
// A solve request first clears the visited marks of all grid cells (a read
// and a write per cell, width times height, capped at MAX_CELLS), checks the
// start in its check and wait states, then pops each cell (pop, pop-wait)
// and gives every neighbor a select state and each in-grid one a wait state,
// as it is read before it is marked and pushed on the single cell store port.
// One request is worked on at a time; the next is taken once the response
// register has been loaded, even if the response is still stalled.

module grid_maze_dfs_solver_top
   import gmd_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEF,
   parameter int MAX_CELLS = MAX_CELLS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   // requests
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [INDEX_W-1:0]   req_cell_index,
   input  logic                 req_cell_wall,
   // responses
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [PATH_W-1:0]    rsp_path_col,
   output logic [PATH_W-1:0]    rsp_path_row,
   output logic                 rsp_path_last
);

   localparam int DW     = $clog2(MAX_DIM + 1);
   localparam int CW     = $clog2(MAX_DIM);
   localparam int IW     = $clog2(MAX_CELLS);
   localparam int LW     = CW + DW + 1;
   localparam int NW     = 2 * DW;
   localparam int SW     = IW + 1;
   localparam int CELL_W = 2 * CW + 2;
   localparam int STK_W  = 2 * CW;
   localparam int DIM_RST = (MAX_DIM < 64) ? MAX_DIM : 64;

   // control registers
   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              ready_ff, ready_in;
   logic [SW-1:0]     depth_ff, depth_in;
   logic [DW-1:0]     width_ff, width_in;
   logic [DW-1:0]     height_ff, height_in;
   logic [START_W-1:0] scol_ff, scol_in;
   logic [START_W-1:0] srow_ff, srow_in;

   // payload registers
   logic [CW-1:0]     cur_row_ff, cur_row_in, cur_col_ff, cur_col_in;
   logic [CW-1:0]     nb_row_ff, nb_row_in, nb_col_ff, nb_col_in;
   logic [CW-1:0]     pc_row_ff, pc_row_in, pc_col_ff, pc_col_in;
   logic [CW-1:0]     ps_row_ff, ps_row_in, ps_col_ff, ps_col_in;
   nbr_type           nb_ff, nb_in;
   logic [SW-1:0]     sweep_ff, sweep_in;
   logic [NW-1:0]     ncells_ff, ncells_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [CW-1:0]     res_col_ff, res_col_in, res_row_ff, res_row_in;
   logic              res_last_ff, res_last_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [PATH_W-1:0] rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic              rsp_last_ff, rsp_last_in;

   // memory ports
   logic              cm_we, sk_we;
   logic [IW-1:0]     cm_addr, sk_addr;
   logic [CELL_W-1:0] cm_wdata, cm_rdata;
   logic [STK_W-1:0]  sk_wdata, sk_rdata;

   // shared terms
   logic              req_fire, rsp_free, cell_free, start_ok, goal_hit, nb_ok;
   logic              sweep_more, at_start, push_ok;
   logic [CW-1:0]     lin_row, lin_col, cand_row, cand_col;
   logic [CW-1:0]     pop_row, pop_col;
   logic              cand_in;
   logic [LW-1:0]     lin;
   logic              lin_ok;
   logic [CFG_W-1:0]  cfg_v;

   gmd_ram #(.WIDTH(CELL_W), .DEPTH(MAX_CELLS)) u_cells (
      .clock(clock), .we(cm_we), .addr(cm_addr), .wdata(cm_wdata), .rdata(cm_rdata)
   );

   gmd_ram #(.WIDTH(STK_W), .DEPTH(MAX_CELLS)) u_stack (
      .clock(clock), .we(sk_we), .addr(sk_addr), .wdata(sk_wdata), .rdata(sk_rdata)
   );

   // handshake terms
   assign req_fire  = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // cell just popped off the stack
   assign pop_row = sk_rdata[CW +: CW];
   assign pop_col = sk_rdata[0 +: CW];

   // cell store fields and search checks
   assign cell_free  = !cm_rdata[0] && !cm_rdata[1];
   assign start_ok   = (32'(scol_ff) < 32'(width_ff)) && (32'(srow_ff) < 32'(height_ff))
                       && lin_ok;
   assign goal_hit   = (32'(pop_col) + 32'd1 == 32'(width_ff))
                       && (32'(pop_row) + 32'd3 == 32'(height_ff));
   assign sweep_more = (32'(sweep_ff) < 32'(ncells_ff)) && (32'(sweep_ff) < MAX_CELLS);
   assign at_start   = (pc_row_ff == ps_row_ff) && (pc_col_ff == ps_col_ff);
   assign push_ok    = 32'(depth_ff) < MAX_CELLS;

   // candidate neighbor of the popped cell
   always_comb begin
      cand_row = cur_row_ff;
      cand_col = cur_col_ff;
      cand_in  = 1'b0;
      unique case (nb_ff)
         NBR_LEFT: begin
            cand_col = cur_col_ff - CW'(1);
            cand_in  = (cur_col_ff != '0);
         end
         NBR_RIGHT: begin
            cand_col = cur_col_ff + CW'(1);
            cand_in  = (32'(cur_col_ff) + 32'd1 < 32'(width_ff));
         end
         NBR_UP: begin
            cand_row = cur_row_ff - CW'(1);
            cand_in  = (cur_row_ff != '0);
         end
         NBR_DOWN: begin
            cand_row = cur_row_ff + CW'(1);
            cand_in  = (32'(cur_row_ff) + 32'd1 < 32'(height_ff));
         end
      endcase
   end

   // linear cell index of the coordinates in use
   always_comb begin
      lin_row = pc_row_ff;
      lin_col = pc_col_ff;
      unique case (state_ff)
         S_ST_CHECK: begin
            lin_row = CW'(srow_ff);
            lin_col = CW'(scol_ff);
         end
         S_ST_WAIT: begin
            lin_row = ps_row_ff;
            lin_col = ps_col_ff;
         end
         S_NB_SEL: begin
            lin_row = cand_row;
            lin_col = cand_col;
         end
         S_NB_WAIT: begin
            lin_row = nb_row_ff;
            lin_col = nb_col_ff;
         end
         default: begin
            lin_row = pc_row_ff;
            lin_col = pc_col_ff;
         end
      endcase
   end

   assign lin    = LW'(lin_row) * LW'(width_ff) + LW'(lin_col);
   assign lin_ok = 32'(lin) < MAX_CELLS;
   assign nb_ok  = cand_in && lin_ok;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_action == ACT_SOLVE) begin
                  state_in = S_CLR_RD;
               end else if (req_action == ACT_READ && ready_ff && !at_start) begin
                  state_in = S_RD_WAIT;
               end else begin
                  state_in = S_RESPOND;
               end
            end
         end
         S_CLR_RD:   state_in = sweep_more ? S_CLR_WR : S_ST_CHECK;
         S_CLR_WR:   state_in = S_CLR_RD;
         S_ST_CHECK: state_in = start_ok ? S_ST_WAIT : S_RESPOND;
         S_ST_WAIT:  state_in = cell_free ? S_POP : S_RESPOND;
         S_POP:      state_in = (depth_ff == '0) ? S_RESPOND : S_POP_WAIT;
         S_POP_WAIT: state_in = goal_hit ? S_RESPOND : S_NB_SEL;
         S_NB_SEL: begin
            if (nb_ok) begin
               state_in = S_NB_WAIT;
            end else if (nb_ff == NBR_DOWN) begin
               state_in = S_POP;
            end
         end
         S_NB_WAIT:  state_in = (nb_ff == NBR_DOWN) ? S_POP : S_NB_SEL;
         S_RD_WAIT:  state_in = S_RESPOND;
         S_RESPOND:  state_in = rsp_free ? S_IDLE : S_RESPOND;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath, memory controls and register updates
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      ready_in      = ready_ff;
      depth_in      = depth_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      scol_in       = scol_ff;
      srow_in       = srow_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      nb_row_in     = nb_row_ff;
      nb_col_in     = nb_col_ff;
      pc_row_in     = pc_row_ff;
      pc_col_in     = pc_col_ff;
      ps_row_in     = ps_row_ff;
      ps_col_in     = ps_col_ff;
      nb_in         = nb_ff;
      sweep_in      = sweep_ff;
      ncells_in     = ncells_ff;
      res_status_in = res_status_ff;
      res_col_in    = res_col_ff;
      res_row_in    = res_row_ff;
      res_last_in   = res_last_ff;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_last_in   = rsp_last_ff;
      cm_we         = 1'b0;
      cm_addr       = IW'(lin);
      cm_wdata      = '0;
      sk_we         = 1'b0;
      sk_addr       = IW'(depth_ff);
      sk_wdata      = {nb_row_ff, nb_col_ff};
      cfg_v         = csr_wdata;

      // response drained
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_status_in = ST_NO_READ;
               res_col_in    = '0;
               res_row_in    = '0;
               res_last_in   = 1'b0;
               ncells_in     = NW'(width_ff) * NW'(height_ff);
               if (req_action == ACT_LOAD) begin
                  // write one cell, clearing visited mark and parent
                  ready_in      = 1'b0;
                  res_status_in = ST_LOADED;
                  cm_addr       = IW'(req_cell_index);
                  cm_we         = 32'(req_cell_index) < MAX_CELLS;
                  cm_wdata      = CELL_W'(req_cell_wall);
               end else if (req_action == ACT_SOLVE) begin
                  ready_in = 1'b0;
                  depth_in = '0;
                  sweep_in = '0;
               end else if (req_action == ACT_READ && ready_ff) begin
                  // emit the path cell and fetch its parent
                  res_status_in = ST_OK;
                  res_col_in    = pc_col_ff;
                  res_row_in    = pc_row_ff;
                  if (at_start) begin
                     res_last_in = 1'b1;
                     ready_in    = 1'b0;
                  end
               end
            end
         end
         S_CLR_RD: begin
            cm_addr = IW'(sweep_ff);
         end
         S_CLR_WR: begin
            cm_addr  = IW'(sweep_ff);
            cm_we    = 1'b1;
            cm_wdata = cm_rdata & ~CELL_W'(2);
            sweep_in = sweep_ff + SW'(1);
         end
         S_ST_CHECK: begin
            ps_row_in = CW'(srow_ff);
            ps_col_in = CW'(scol_ff);
            if (!start_ok) begin
               res_status_in = ST_NO_PATH;
            end
         end
         S_ST_WAIT: begin
            if (cell_free) begin
               cm_we    = 1'b1;
               cm_wdata = CELL_W'(2);
               sk_we    = 1'b1;
               sk_addr  = '0;
               sk_wdata = {ps_row_ff, ps_col_ff};
               depth_in = SW'(1);
            end else begin
               res_status_in = ST_NO_PATH;
            end
         end
         S_POP: begin
            sk_addr = IW'(depth_ff - SW'(1));
            if (depth_ff == '0) begin
               res_status_in = ST_NO_PATH;
            end else begin
               depth_in = depth_ff - SW'(1);
            end
         end
         S_POP_WAIT: begin
            cur_row_in = pop_row;
            cur_col_in = pop_col;
            nb_in      = NBR_LEFT;
            if (goal_hit) begin
               pc_row_in     = pop_row;
               pc_col_in     = pop_col;
               ready_in      = 1'b1;
               depth_in      = '0;
               res_status_in = ST_OK;
            end
         end
         S_NB_SEL: begin
            nb_row_in = cand_row;
            nb_col_in = cand_col;
            if (!nb_ok && nb_ff != NBR_DOWN) begin
               nb_in = nbr_type'(nb_ff + 2'd1);
            end
         end
         S_NB_WAIT: begin
            // mark visited, link parent and push
            if (cell_free && push_ok) begin
               cm_we    = 1'b1;
               cm_wdata = {cur_row_ff, cur_col_ff, 1'b1, 1'b0};
               sk_we    = 1'b1;
               depth_in = depth_ff + SW'(1);
            end
            if (nb_ff != NBR_DOWN) begin
               nb_in = nbr_type'(nb_ff + 2'd1);
            end
         end
         S_RD_WAIT: begin
            pc_row_in = cm_rdata[2 + CW +: CW];
            pc_col_in = cm_rdata[2 +: CW];
         end
         S_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_col_in    = PATH_W'(res_col_ff);
               rsp_row_in    = PATH_W'(res_row_ff);
               rsp_last_in   = res_last_ff;
            end
         end
         default: begin
            cm_we = 1'b0;
         end
      endcase

      // configuration writes; width and height saturated to their legal ranges
      if (csr_we) begin
         ready_in = 1'b0;
         unique case (csr_index)
            REG_GRID_WIDTH: begin
               if (cfg_v == '0) begin
                  width_in = DW'(1);
               end else if (32'(cfg_v) > MAX_DIM) begin
                  width_in = DW'(MAX_DIM);
               end else begin
                  width_in = DW'(cfg_v);
               end
            end
            REG_GRID_HEIGHT: begin
               if (32'(cfg_v) < 32'd3) begin
                  height_in = DW'(3);
               end else if (32'(cfg_v) > MAX_DIM) begin
                  height_in = DW'(MAX_DIM);
               end else begin
                  height_in = DW'(cfg_v);
               end
            end
            REG_START_COL: scol_in = cfg_v[START_W-1:0];
            REG_START_ROW: srow_in = cfg_v[START_W-1:0];
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ready_ff     <= 1'b0;
         depth_ff     <= '0;
         width_ff     <= DW'(DIM_RST);
         height_ff    <= DW'(DIM_RST);
         scol_ff      <= '0;
         srow_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ready_ff     <= ready_in;
         depth_ff     <= depth_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         scol_ff      <= scol_in;
         srow_ff      <= srow_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      nb_row_ff     <= nb_row_in;
      nb_col_ff     <= nb_col_in;
      pc_row_ff     <= pc_row_in;
      pc_col_ff     <= pc_col_in;
      ps_row_ff     <= ps_row_in;
      ps_col_ff     <= ps_col_in;
      nb_ff         <= nb_in;
      sweep_ff      <= sweep_in;
      ncells_ff     <= ncells_in;
      res_status_ff <= res_status_in;
      res_col_ff    <= res_col_in;
      res_row_ff    <= res_row_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_path_col  = rsp_col_ff;
   assign rsp_path_row  = rsp_row_ff;
   assign rsp_path_last = rsp_last_ff;

endmodule

@@ sim/grid_maze_dfs_solver_top_test.sv @@
// testbench for the grid maze depth-first solver: loads grids, runs searches
// and walks the parent path, checking every response against its own predictor
// depends on gmd_pkg and grid_maze_dfs_solver_top

module grid_maze_dfs_solver_top_test;
   import gmd_pkg::*;

   localparam int CELLS      = MAX_CELLS_DEF;
   localparam int DIM        = MAX_DIM_DEF;
   localparam int IDLE_LIMIT = 40000;
   localparam int HOLD_LEN   = 400;
   localparam int RAND_ITEMS = 1650;
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PATH_W-1:0]   col;
      logic [PATH_W-1:0]   row;
      logic                last;
   } rsp_type;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 csr_we = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic [ACTION_W-1:0]  req_action = '0;
   logic [INDEX_W-1:0]   req_cell_index = '0;
   logic                 req_cell_wall = 0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [PATH_W-1:0]    rsp_path_col;
   logic [PATH_W-1:0]    rsp_path_row;
   logic                 rsp_path_last;

   // predictor state
   bit          cell_wall_m [CELLS];
   bit          cell_seen_m [CELLS];
   int          cell_parent_m [CELLS];
   int          dfs_stack [CELLS];
   int          grid_w, grid_h, start_c, start_r;
   int          path_at, start_at;
   bit          path_valid;

   rsp_type     expected_q [$];
   int          errors = 0;
   int          sent = 0;
   int          checked = 0;
   int          paths_found = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          quiet = 0;
   bit          hold_rsp = 0;

   grid_maze_dfs_solver_top DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_cell_index(req_cell_index), .req_cell_wall(req_cell_wall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_path_col(rsp_path_col), .rsp_path_row(rsp_path_row),
      .rsp_path_last(rsp_path_last)
   );

   always #2 clock = ~clock;

   // depth-first search over the predicted grid, returns the solve status
   function automatic logic [STATUS_W-1:0] search_grid();
      int depth, cur, c, r, goal, nb;
      path_valid = 0;
      depth = 0;
      for (int i = 0; i < grid_w * grid_h && i < CELLS; i++) cell_seen_m[i] = 0;
      if (start_c >= grid_w || start_r >= grid_h) return ST_NO_PATH;
      start_at = start_r * grid_w + start_c;
      if (cell_wall_m[start_at] || cell_seen_m[start_at]) return ST_NO_PATH;
      cell_seen_m[start_at] = 1;
      cell_parent_m[start_at] = 0;
      dfs_stack[depth++] = start_at;
      goal = (grid_h - 3) * grid_w + grid_w - 1;
      while (depth > 0) begin
         depth--;
         cur = dfs_stack[depth];
         c = cur % grid_w;
         r = cur / grid_w;
         if (cur == goal) begin
            path_at = cur;
            path_valid = 1;
            return ST_OK;
         end
         // neighbors in the order left, right, up, down
         for (int k = 0; k < 4; k++) begin
            nb = -1;
            case (nbr_type'(k))
               NBR_LEFT:  if (c > 0) nb = cur - 1;
               NBR_RIGHT: if (c + 1 < grid_w) nb = cur + 1;
               NBR_UP:    if (r > 0) nb = cur - grid_w;
               NBR_DOWN:  if (r + 1 < grid_h) nb = cur + grid_w;
            endcase
            if (nb >= 0 && nb < CELLS && !cell_wall_m[nb] && !cell_seen_m[nb]) begin
               cell_seen_m[nb] = 1;
               cell_parent_m[nb] = cur;
               dfs_stack[depth++] = nb;
            end
         end
      end
      return ST_NO_PATH;
   endfunction

   // expected response of one accepted request
   function automatic rsp_type predict_rsp(logic [ACTION_W-1:0] act,
                                           logic [INDEX_W-1:0] idx, logic wall);
      rsp_type e;
      e = '0;
      if (act == ACT_LOAD) begin
         path_valid = 0;
         cell_wall_m[idx] = wall;
         cell_seen_m[idx] = 0;
         cell_parent_m[idx] = 0;
         e.status = ST_LOADED;
      end else if (act == ACT_SOLVE) begin
         e.status = search_grid();
         if (e.status == ST_OK) paths_found++;
      end else if (act == ACT_READ && path_valid) begin
         e.status = ST_OK;
         e.col = PATH_W'(path_at % grid_w);
         e.row = PATH_W'(path_at / grid_w);
         if (path_at == start_at) begin
            e.last = 1;
            path_valid = 0;
         end else begin
            path_at = cell_parent_m[path_at];
         end
      end else begin
         e.status = ST_NO_READ;
      end
      return e;
   endfunction

   // send one request and record its expected response at acceptance
   task automatic send_req(input logic [ACTION_W-1:0] act, input logic [INDEX_W-1:0] idx,
                           input logic wall);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= act;
      req_cell_index <= idx;
      req_cell_wall <= wall;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(predict_rsp(act, idx, wall));
      sent++;
   endtask

   // drop valid and let every outstanding response drain
   task automatic wait_idle();
      req_valid <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      int v;
      wait_idle();
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      path_valid = 0;
      v = val;
      case (idx)
         REG_GRID_WIDTH:  grid_w = v < 1 ? 1 : (v > DIM ? DIM : v);
         REG_GRID_HEIGHT: grid_h = v < 3 ? 3 : (v > DIM ? DIM : v);
         REG_START_COL:   start_c = val[START_W-1:0];
         REG_START_ROW:   start_r = val[START_W-1:0];
      endcase
      @(posedge clock);
      csr_we <= 0;
   endtask

   // fill every cell of the grid in use, walls at the given percentage
   task automatic load_grid(input int wall_pct);
      for (int i = 0; i < grid_w * grid_h; i++)
         send_req(ACT_LOAD, INDEX_W'(i), $urandom_range(0, 99) < wall_pct);
   endtask

   // read the whole path and one request past its end
   task automatic read_path();
      while (path_valid) send_req(ACT_READ, '0, 1'($urandom_range(0, 1)));
      send_req(ACT_READ, INDEX_W'($urandom), 1'($urandom_range(0, 1)));
   endtask

   task automatic setup_grid(input int w, input int h, input int sc, input int sr);
      write_reg(REG_GRID_WIDTH, CFG_W'(w));
      write_reg(REG_GRID_HEIGHT, CFG_W'(h));
      write_reg(REG_START_COL, CFG_W'(sc));
      write_reg(REG_START_ROW, CFG_W'(sr));
   endtask

   // reads and unknown actions straight after reset
   task automatic test_reset_state();
      send_req(ACT_READ, '0, 0);
      send_req(ACT_NONE, 12'hfff, 1);
   endtask

   // start on the goal, start on a wall, start outside the grid
   task automatic test_start_cases();
      setup_grid(0, 0, 0, 0);
      load_grid(0);
      send_req(ACT_SOLVE, '0, 0);
      read_path();
      send_req(ACT_LOAD, 12'd0, 1);
      send_req(ACT_SOLVE, '0, 0);
      send_req(ACT_READ, '0, 0);
      write_reg(REG_START_ROW, 7'd63);
      write_reg(REG_START_COL, 7'd63);
      send_req(ACT_SOLVE, '0, 0);
      send_req(ACT_NONE, '0, 0);
   endtask

   // widest and tallest grids, open and with a wall cutting the goal off
   task automatic test_extreme_grids();
      setup_grid(127, 2, 0, 0);
      load_grid(0);
      send_req(ACT_SOLVE, '0, 0);
      read_path();
      setup_grid(0, 64, 0, 63);
      load_grid(0);
      send_req(ACT_SOLVE, '0, 0);
      send_req(ACT_READ, '0, 0);
      send_req(ACT_READ, '0, 0);
      send_req(ACT_LOAD, 12'd62, 1);
      send_req(ACT_SOLVE, '0, 0);
      send_req(ACT_READ, '0, 0);
   endtask

   // the receiver holds off while loads keep coming
   task automatic test_backpressure();
      setup_grid(8, 8, 0, 0);
      quiet = 1;
      hold_rsp = 1;
      load_grid(20);
      send_req(ACT_SOLVE, '0, 0);
      read_path();
      quiet = 0;
   endtask

   // random grids, searches, path walks and noise
   task automatic test_random_mazes();
      int w, h, rounds, pick;
      while (sent < RAND_ITEMS - 40) begin
         quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            w = 64; h = 3;
         end else if (pick == 1) begin
            w = 1; h = 64;
         end else begin
            w = $urandom_range(1, 10); h = $urandom_range(3, 10);
         end
         if ($urandom_range(0, 9) == 0)
            setup_grid(w, h, $urandom_range(0, 63), $urandom_range(0, 63));
         else
            setup_grid(w, h, $urandom_range(0, w - 1), $urandom_range(0, h - 1));
         load_grid($urandom_range(5, 35));
         rounds = $urandom_range(2, 5);
         for (int k = 0; k < rounds; k++) begin
            send_req(ACT_SOLVE, INDEX_W'($urandom), 1'($urandom_range(0, 1)));
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               read_path();
            end else if (pick < 8) begin
               // path broken by a load partway through
               repeat ($urandom_range(0, 3)) send_req(ACT_READ, INDEX_W'($urandom), 0);
               send_req(ACT_LOAD, INDEX_W'($urandom_range(0, w * h - 1)),
                        1'($urandom_range(0, 1)));
               send_req(ACT_READ, '0, 0);
            end else begin
               send_req(ACT_NONE, INDEX_W'($urandom), 1'($urandom_range(0, 1)));
               send_req(ACT_LOAD, INDEX_W'($urandom), 1'($urandom_range(0, 1)));
               send_req(ACT_READ, '0, 0);
            end
            if ($urandom_range(0, 3) == 0) begin
               write_reg(REG_START_COL, CFG_W'($urandom_range(0, w - 1)));
               write_reg(REG_START_ROW, CFG_W'($urandom_range(0, h - 1)));
            end
         end
      end
      quiet = 0;
   endtask

   // receiver stalls, drawn per response, with one long hold when asked
   always @(posedge clock) begin
      if (hold_rsp) begin
         stall_left = HOLD_LEN;
         hold_rsp = 0;
      end else if (rsp_valid && !rsp_stall) begin
         stall_left = quiet ? 0 : $urandom_range(0, 13);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left--;
      end else begin
         rsp_stall <= 0;
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("response with none expected: status %0d", rsp_status);
            errors++;
         end else begin
            e = expected_q.pop_front();
            checked++;
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_path_col !== e.col) begin
               $error("path_col expected %0d actual %0d", e.col, rsp_path_col);
               errors++;
            end
            if (rsp_path_row !== e.row) begin
               $error("path_row expected %0d actual %0d", e.row, rsp_path_row);
               errors++;
            end
            if (rsp_path_last !== e.last) begin
               $error("path_last expected %0d actual %0d", e.last, rsp_path_last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      grid_w = DIM; grid_h = DIM; start_c = 0; start_r = 0;
      path_at = 0; start_at = 0; path_valid = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_state();
      test_start_cases();
      test_extreme_grids();
      test_backpressure();
      test_random_mazes();
      wait_idle();
      repeat (50) @(posedge clock);
      $display("sent %0d requests, checked %0d responses, %0d searches found a path",
               sent, checked, paths_found);
      $display("grids from 1x3 up to 64x3 and 1x64, with bad starts and broken paths");
      if (errors == 0 && expected_q.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/gmd_pkg.sv
rtl/gmd_ram.sv
rtl/grid_maze_dfs_solver_top.sv
sim/grid_maze_dfs_solver_top_test.sv
